// File: sv/mrrs_pkg.sv
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared types, codes and constants of the MIDI request/reply sequencer.
// ----------------------------------------------------------------------------
package mrrs_pkg;

   // fixed field widths
   localparam int LEN_W = 6;    // name length, covers up to 63 characters
   localparam int IDX_W = 8;    // reply byte index, covers up to 255 bytes

   // default sizes
   localparam int REPLY_BYTES_DEF = 128;
   localparam int NAME_CHARS_DEF  = 31;

   // register reset values
   localparam logic [15:0] TIMEOUT_RST = 16'd300;
   localparam logic [15:0] POLL_RST    = 16'd1000;
   localparam logic [3:0]  RETRIES_RST = 4'd2;
   localparam logic [6:0]  OFFSET_RST  = 7'd10;

   // register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_POLL    = 2'd1;
   localparam logic [1:0] CSR_RETRIES = 2'd2;
   localparam logic [1:0] CSR_OFFSET  = 2'd3;

   // request kinds
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SUBMIT = 2'd1;
   localparam logic [1:0] CMD_REPLY  = 2'd2;

   // submitted command types
   localparam logic [1:0] TYPE_NONE = 2'd0;
   localparam logic [1:0] TYPE_PROG = 2'd1;
   localparam logic [1:0] TYPE_CTRL = 2'd2;
   localparam logic [1:0] TYPE_NAME = 2'd3;

   // reply byte classes
   localparam logic [7:0] BYTE_EOX   = 8'hF7;
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_PROG      = 3'd1,
      ACT_CTRL      = 3'd2,
      ACT_NAME_REQ  = 3'd3,
      ACT_NAME_CHAR = 3'd4,
      ACT_BUSY      = 3'd5,
      ACT_DROP      = 3'd6
   } action_type;

   // one unit of output work, handed from front to back
   typedef struct packed {
      action_type       action;
      logic [3:0]       channel;
      logic [6:0]       val_a;
      logic [6:0]       val_b;
      logic [LEN_W-1:0] run_len;
      logic             connected;
      logic             busy;
   } job_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_FETCH = 3'b010,
      BK_LOAD  = 3'b100
   } bk_state_type;

endpackage

// File: sv/midi_request_reply_sequencer_top.sv
// A single-result request goes through the job queue, then the response register.
// Throughput: one request per cycle while the queue has room and no name run is open.
// A name run goes through the queue, then each character is fetched from the store
// and registered; new requests are held off until the last is loaded.
// Reset: synchronous, clears all control state and restores register defaults;
// the name store is not cleared.
// ----------------------------------------------------------------------------
// midi_request_reply_sequencer_top
// MIDI request/reply sequencer: front decoder, job queue, name store, back
// result sequencer.
// ----------------------------------------------------------------------------
module midi_request_reply_sequencer_top
   import mrrs_pkg::*;
#(
   parameter int REPLY_BYTES = REPLY_BYTES_DEF,
   parameter int NAME_CHARS  = NAME_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_cmd_type,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_value_a,
   input  logic [6:0]  req_value_b,
   input  logic [7:0]  req_reply_byte,
   input  logic        req_reply_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_out_a,
   output logic [6:0]  rsp_out_b,
   output logic [6:0]  rsp_name_char,
   output logic        rsp_run_last,
   output logic        rsp_connected,
   output logic        rsp_busy_res,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

   q_status_type q_status;
   job_type      push_job, head_job;
   logic         job_push, pop, run_done;
   logic         store_we;
   logic [AW-1:0] store_addr, rd_addr;
   logic [6:0]   store_data, rd_data;

   // request decoder and link state
   mrrs_front #(
      .REPLY_BYTES (REPLY_BYTES),
      .NAME_CHARS  (NAME_CHARS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_cmd_type   (req_cmd_type),
      .req_channel    (req_channel),
      .req_value_a    (req_value_a),
      .req_value_b    (req_value_b),
      .req_reply_byte (req_reply_byte),
      .req_reply_last (req_reply_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .run_done       (run_done),
      .job_push       (job_push),
      .job            (push_job),
      .store_we       (store_we),
      .store_addr     (store_addr),
      .store_data     (store_data)
   );

   // job queue
   mrrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // name character store
   mrrs_ram #(
      .WIDTH (7),
      .DEPTH (NAME_CHARS)
   ) u_name_ram (
      .clock      (clock),
      .wr_en      (store_we),
      .wr_addr    (store_addr),
      .wr_data    (store_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // result sequencer
   mrrs_back #(
      .NAME_CHARS (NAME_CHARS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head_job        (head_job),
      .pop             (pop),
      .run_done        (run_done),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_a       (rsp_out_a),
      .rsp_out_b       (rsp_out_b),
      .rsp_name_char   (rsp_name_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_connected   (rsp_connected),
      .rsp_busy_res    (rsp_busy_res)
   );

endmodule

// File: sv/mrrs_ram.sv
// ----------------------------------------------------------------------------
// mrrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mrrs_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 31
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: sv/mrrs_queue.sv
// ----------------------------------------------------------------------------
// mrrs_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mrrs_queue
   import mrrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type status
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_job     = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/mrrs_front.sv
// ----------------------------------------------------------------------------
// mrrs_front
// Accepts requests, keeps the link state and timers, stores name characters
// and hands one job per result-producing request to the queue.
// ----------------------------------------------------------------------------
module mrrs_front
   import mrrs_pkg::*;
#(
   parameter int REPLY_BYTES = REPLY_BYTES_DEF,
   parameter int NAME_CHARS  = NAME_CHARS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_valid,
   output logic                                               req_stall,
   input  logic [1:0]                                         req_command,
   input  logic [1:0]                                         req_cmd_type,
   input  logic [3:0]                                         req_channel,
   input  logic [6:0]                                         req_value_a,
   input  logic [6:0]                                         req_value_b,
   input  logic [7:0]                                         req_reply_byte,
   input  logic                                               req_reply_last,
   input  logic                                               csr_we,
   input  logic [1:0]                                         csr_index,
   input  logic [15:0]                                        csr_wdata,
   input  q_status_type                                       q_status,
   input  logic                                               run_done,
   output logic                                               job_push,
   output job_type                                            job,
   output logic                                               store_we,
   output logic [((NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1)-1:0] store_addr,
   output logic [6:0]                                         store_data
);

   localparam int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

   // configuration registers
   logic [15:0] reply_timeout_ff;
   logic [15:0] poll_interval_ff;
   logic [3:0]  max_retries_ff;
   logic [6:0]  name_offset_ff;

   // sequencer state
   logic             awaiting_ff, awaiting_in;
   logic [15:0]      wait_ticks_ff, wait_ticks_in;
   logic [15:0]      poll_ticks_ff, poll_ticks_in;
   logic [3:0]       retries_ff, retries_in;
   logic [IDX_W-1:0] reply_index_ff, reply_index_in;
   logic [LEN_W-1:0] name_length_ff, name_length_in;
   logic             name_ended_ff, name_ended_in;
   logic             link_up_ff, link_up_in;
   logic             run_pending_ff, run_pending_in;

   logic        accept;
   logic        do_fail, do_start, do_success;
   logic [15:0] poll_inc, wait_inc;

   // a name run must leave the store before the next request may touch it
   assign req_stall = q_status.full || run_pending_ff;
   assign accept    = req_valid && !req_stall;

   assign poll_inc = (poll_ticks_ff == 16'hFFFF) ? poll_ticks_ff : poll_ticks_ff + 16'd1;
   assign wait_inc = (wait_ticks_ff == 16'hFFFF) ? wait_ticks_ff : wait_ticks_ff + 16'd1;

   assign store_addr = name_length_ff[AW-1:0];
   assign store_data = req_reply_byte[6:0];

   // request decode and next state
   always_comb begin
      awaiting_in    = awaiting_ff;
      wait_ticks_in  = wait_ticks_ff;
      poll_ticks_in  = poll_ticks_ff;
      retries_in     = retries_ff;
      reply_index_in = reply_index_ff;
      name_length_in = name_length_ff;
      name_ended_in  = name_ended_ff;
      link_up_in     = link_up_ff;
      do_fail        = 1'b0;
      do_start       = 1'b0;
      do_success     = 1'b0;
      store_we       = 1'b0;
      job_push       = 1'b0;
      job            = '0;

      if (accept) begin
         unique case (req_command)
            CMD_TICK: begin
               poll_ticks_in = poll_inc;
               if (awaiting_ff) begin
                  wait_ticks_in = wait_inc;
                  if (wait_inc >= reply_timeout_ff) begin
                     do_fail = 1'b1;
                  end
               end else if (poll_inc >= poll_interval_ff) begin
                  poll_ticks_in = 16'd0;
                  do_start      = 1'b1;
               end
            end
            CMD_SUBMIT: begin
               if (awaiting_ff) begin
                  job_push   = 1'b1;
                  job.action = ACT_BUSY;
               end else begin
                  unique case (req_cmd_type)
                     TYPE_PROG: begin
                        job_push    = 1'b1;
                        job.action  = ACT_PROG;
                        job.channel = req_channel;
                        job.val_a   = req_value_a;
                     end
                     TYPE_CTRL: begin
                        job_push    = 1'b1;
                        job.action  = ACT_CTRL;
                        job.channel = req_channel;
                        job.val_a   = req_value_a;
                        job.val_b   = req_value_b;
                     end
                     TYPE_NAME: do_start = 1'b1;
                     TYPE_NONE: ;
                     default: ;
                  endcase
               end
            end
            CMD_REPLY: begin
               if (awaiting_ff) begin
                  if (reply_index_ff < IDX_W'(REPLY_BYTES)) begin
                     if (reply_index_ff >= {1'b0, name_offset_ff} && !name_ended_ff) begin
                        if (req_reply_byte == BYTE_EOX || req_reply_byte == BYTE_NUL) begin
                           name_ended_in = 1'b1;
                        end else if (req_reply_byte >= PRINT_LO &&
                                     req_reply_byte <= PRINT_HI &&
                                     name_length_ff < LEN_W'(NAME_CHARS)) begin
                           store_we       = 1'b1;
                           name_length_in = name_length_ff + LEN_W'(1);
                        end
                     end
                     reply_index_in = reply_index_ff + IDX_W'(1);
                  end
                  if (req_reply_last) begin
                     if (reply_index_in < ({1'b0, name_offset_ff} + IDX_W'(1)) ||
                         name_length_in == '0) begin
                        do_fail = 1'b1;
                     end else begin
                        do_success = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // new request: fresh reply window
      if (do_start) begin
         awaiting_in    = 1'b1;
         retries_in     = 4'd0;
         reply_index_in = '0;
         name_length_in = '0;
         name_ended_in  = 1'b0;
         wait_ticks_in  = 16'd0;
         job_push       = 1'b1;
         job.action     = ACT_NAME_REQ;
      end

      // failure: resend or drop
      if (do_fail) begin
         link_up_in     = 1'b0;
         reply_index_in = '0;
         name_length_in = '0;
         name_ended_in  = 1'b0;
         wait_ticks_in  = 16'd0;
         job_push       = 1'b1;
         if (retries_ff < max_retries_ff) begin
            retries_in = retries_ff + 4'd1;
            job.action = ACT_NAME_REQ;
         end else begin
            retries_in  = 4'd0;
            awaiting_in = 1'b0;
            job.action  = ACT_DROP;
         end
      end

      // good reply: emit the stored name
      if (do_success) begin
         job_push       = 1'b1;
         job.action     = ACT_NAME_CHAR;
         job.run_len    = name_length_in;
         link_up_in     = 1'b1;
         retries_in     = 4'd0;
         awaiting_in    = 1'b0;
         reply_index_in = '0;
         name_length_in = '0;
         name_ended_in  = 1'b0;
         wait_ticks_in  = 16'd0;
      end

      job.connected = link_up_in;
      job.busy      = awaiting_in;
   end

   // name run tracking
   always_comb begin
      run_pending_in = run_pending_ff;
      if (do_success) begin
         run_pending_in = 1'b1;
      end else if (run_done) begin
         run_pending_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff    <= 1'b0;
         wait_ticks_ff  <= 16'd0;
         poll_ticks_ff  <= 16'd0;
         retries_ff     <= 4'd0;
         reply_index_ff <= '0;
         name_length_ff <= '0;
         name_ended_ff  <= 1'b0;
         link_up_ff     <= 1'b0;
         run_pending_ff <= 1'b0;
      end else begin
         awaiting_ff    <= awaiting_in;
         wait_ticks_ff  <= wait_ticks_in;
         poll_ticks_ff  <= poll_ticks_in;
         retries_ff     <= retries_in;
         reply_index_ff <= reply_index_in;
         name_length_ff <= name_length_in;
         name_ended_ff  <= name_ended_in;
         link_up_ff     <= link_up_in;
         run_pending_ff <= run_pending_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reply_timeout_ff <= TIMEOUT_RST;
         poll_interval_ff <= POLL_RST;
         max_retries_ff   <= RETRIES_RST;
         name_offset_ff   <= OFFSET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT: reply_timeout_ff <= csr_wdata;
            CSR_POLL:    poll_interval_ff <= csr_wdata;
            CSR_RETRIES: max_retries_ff   <= csr_wdata[3:0];
            CSR_OFFSET:  name_offset_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

endmodule

// File: sv/mrrs_back.sv
// ----------------------------------------------------------------------------
// mrrs_back
// Takes jobs from the queue and drives the response register; a name job is
// played out one character at a time from the name store.
// ----------------------------------------------------------------------------
module mrrs_back
   import mrrs_pkg::*;
#(
   parameter int NAME_CHARS = NAME_CHARS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  q_status_type                                       q_status,
   input  job_type                                            head_job,
   output logic                                               pop,
   output logic                                               run_done,
   output logic [((NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1)-1:0] rd_addr,
   input  logic [6:0]                                         rd_data,
   output logic                                               rsp_valid,
   input  logic                                               rsp_stall,
   output logic [2:0]                                         rsp_action,
   output logic [3:0]                                         rsp_out_channel,
   output logic [6:0]                                         rsp_out_a,
   output logic [6:0]                                         rsp_out_b,
   output logic [6:0]                                         rsp_name_char,
   output logic                                               rsp_run_last,
   output logic                                               rsp_connected,
   output logic                                               rsp_busy_res
);

   localparam int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

   bk_state_type     state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   job_type          run_job_ff;
   logic             out_free;
   logic             load_single, load_char, char_last;

   // response register payload
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       action_ff;
   logic [3:0]       channel_ff;
   logic [6:0]       a_ff, b_ff, char_ff;
   logic             last_ff, conn_ff, busy_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_addr   = idx_ff[AW-1:0];
   assign char_last = (idx_ff == run_job_ff.run_len - LEN_W'(1));

   // sequencing of jobs and name characters
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      load_single = 1'b0;
      load_char   = 1'b0;
      run_done    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               pop = 1'b1;
               if (head_job.action == ACT_NAME_CHAR) begin
                  idx_in   = '0;
                  state_in = BK_FETCH;
               end else begin
                  load_single = 1'b1;
               end
            end
         end
         BK_FETCH: state_in = BK_LOAD;
         BK_LOAD: begin
            if (out_free) begin
               load_char = 1'b1;
               if (char_last) begin
                  run_done = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = BK_FETCH;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // valid flag of the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_single || load_char) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // held name job and response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         run_job_ff <= head_job;
      end
      if (load_single) begin
         action_ff  <= head_job.action;
         channel_ff <= head_job.channel;
         a_ff       <= head_job.val_a;
         b_ff       <= head_job.val_b;
         char_ff    <= 7'd0;
         last_ff    <= 1'b1;
         conn_ff    <= head_job.connected;
         busy_ff    <= head_job.busy;
      end else if (load_char) begin
         action_ff  <= ACT_NAME_CHAR;
         channel_ff <= 4'd0;
         a_ff       <= 7'd0;
         b_ff       <= 7'd0;
         char_ff    <= rd_data;
         last_ff    <= char_last;
         conn_ff    <= run_job_ff.connected;
         busy_ff    <= run_job_ff.busy;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_out_channel = channel_ff;
   assign rsp_out_a       = a_ff;
   assign rsp_out_b       = b_ff;
   assign rsp_name_char   = char_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_connected   = conn_ff;
   assign rsp_busy_res    = busy_ff;

endmodule

// File: sv/mrrs_checker.sv
// ----------------------------------------------------------------------------
// mrrs_checker
// Port-level checks of the MIDI request/reply sequencer, bound to the top.
// ----------------------------------------------------------------------------
module mrrs_checker
   import mrrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_action,
   input logic [6:0]  rsp_name_char,
   input logic        rsp_run_last,
   input logic        rsp_connected,
   input logic        rsp_busy_res
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action) &&
                                 $stable(rsp_name_char) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // a name character only comes with the link up and no request pending
   a_char_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NAME_CHAR |-> rsp_connected && !rsp_busy_res)
      else $error("name character without link up");

   // a drop leaves the link down and idle
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_DROP |-> !rsp_connected && !rsp_busy_res &&
                                             rsp_run_last)
      else $error("drop with wrong status");

   // a sent name request or a busy reject always reports waiting
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_NAME_REQ || rsp_action == ACT_BUSY)
      |-> rsp_busy_res && rsp_run_last)
      else $error("request or reject without busy status");

   // character field only set on name characters
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_NAME_CHAR |-> rsp_name_char == 7'd0)
      else $error("name character on other action");

endmodule

bind midi_request_reply_sequencer_top mrrs_checker u_checker (.*);
